// ----- hdl/spk_pkg.sv -----
// shared widths, register indexes and controller/datapath interface types
package spk_pkg;

	// working value width: 16 integer bits and 8 fraction bits
	localparam int VW   = 24;
	// divisor width, enough for a segment length of up to 64 samples
	localparam int DENW = 7;
	// sample and configuration data width
	localparam int SW   = 16;
	// configuration index width
	localparam int IDXW = 8;

	// configuration register indexes
	localparam logic [IDXW-1:0] REG_RANGE_LOW   = 8'd0;
	localparam logic [IDXW-1:0] REG_RANGE_HIGH  = 8'd1;
	localparam logic [IDXW-1:0] REG_FRACTION    = 8'd2;
	localparam logic [IDXW-1:0] REG_SPIKE_WIDTH = 8'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic lim;
		logic rd_cur;
		logic cut;
		logic jmp;
		logic fill_init;
		logic fill_wr;
		logic rst;
		logic rst2;
		logic slope_go;
		logic slope_take;
		logic ramp_wr;
		logic close;
		logic avg_go;
		logic avg_take;
		logic out_rd;
		logic out_load;
		logic out_next;
		logic clear;
	} spk_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic big;
		logic is_ramp;
		logic seg_eq_i;
		logic fill_done;
		logic div_done;
		logic ramp_done;
		logic last_item;
		logic out_fire;
		logic out_last;
	} spk_stat_t;

endpackage

// ----- hdl/distance_spike_filter.sv -----
// top level of the distance spike filter
//
// channel   signals                                   direction
// in        in_valid in_ready distance last_sample    sink
// out       out_valid out_ready filtered_distance     source
//           last_out
// cfg       cfg_valid cfg_ready cfg_index cfg_data    sink, always ready
//
// loading takes one cycle per input beat; the set is stored in a single ram.
// filtering steps each sample through read, cut, jump and decision states and the running
// average divide (12 two-bit steps); a closing jump adds the close state plus one fill
// write per sample filled, a ramp adds setup, its own divide and close plus one write
// per ramp sample; each output beat takes a ram read, a register load and a handshake.
// reset returns to loading with an empty set; a stalled output beat holds the block,
// and no input is taken until the last filtered beat of the set has gone.
module distance_spike_filter #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spk_pkg::SW-1:0]       distance,
	input  logic                         last_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spk_pkg::SW-1:0]       filtered_distance,
	output logic                         last_out,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [spk_pkg::IDXW-1:0]     cfg_index,
	input  logic [spk_pkg::SW-1:0]       cfg_data
);

	spk_pkg::spk_cmd_t  cmd;
	spk_pkg::spk_stat_t stat;

	// configuration beats are always taken
	assign cfg_ready = 1'b1;

	// controller
	spk_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	// datapath
	spk_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.distance          (distance),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.filtered_distance (filtered_distance),
		.last_out          (last_out)
	);

endmodule

// ----- hdl/spk_ram.sv -----
// generic single write port, single read port ram with registered read
module spk_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/spk_div.sv -----
// signed by unsigned iterative divider, two quotient bits a cycle, truncating
module spk_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [spk_pkg::VW:0]   num,
	input  logic [spk_pkg::DENW-1:0]      den,
	output logic                          done,
	output logic signed [spk_pkg::VW:0]   quo
);

	localparam int VW    = spk_pkg::VW;
	localparam int DENW  = spk_pkg::DENW;
	localparam int STEPS = VW / 2;
	localparam int CNTW  = $clog2(STEPS);

	logic [DENW-1:0] rem_q;
	logic [VW-1:0]   quo_q;
	logic [DENW-1:0] den_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DENW:0]   t1, t2;
	logic [DENW-1:0] r1, r2;
	logic [VW-1:0]   q1, q2;
	logic [VW-1:0]   mag;

	// magnitude of the dividend
	assign mag = num[VW] ? VW'(-num) : num[VW-1:0];

	// two restoring steps
	always_comb begin
		t1 = {rem_q, quo_q[VW-1]};
		q1 = {quo_q[VW-2:0], 1'b0};
		if (t1 >= {1'b0, den_q}) begin
			r1    = DENW'(t1 - {1'b0, den_q});
			q1[0] = 1'b1;
		end else begin
			r1 = t1[DENW-1:0];
		end
		t2 = {r1, q1[VW-1]};
		q2 = {q1[VW-2:0], 1'b0};
		if (t2 >= {1'b0, den_q}) begin
			r2    = DENW'(t2 - {1'b0, den_q});
			q2[0] = 1'b1;
		end else begin
			r2 = t2[DENW-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= den;
			neg_q <= num[VW];
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= q2;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ----- hdl/spk_dp.sv -----
// datapath: configuration, sample store, limits, segment and ramp arithmetic
module spk_dp #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spk_pkg::spk_cmd_t            cmd,
	output spk_pkg::spk_stat_t           stat,
	input  logic                         cfg_we,
	input  logic [spk_pkg::IDXW-1:0]     cfg_index,
	input  logic [spk_pkg::SW-1:0]       cfg_data,
	input  logic [spk_pkg::SW-1:0]       distance,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spk_pkg::SW-1:0]       filtered_distance,
	output logic                         last_out
);

	localparam int VW   = spk_pkg::VW;
	localparam int SW   = spk_pkg::SW;
	localparam int DENW = spk_pkg::DENW;
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);

	// configuration registers
	logic [SW-1:0] rl_q, rh_q, frac_q;
	logic [7:0]    spike_q;

	// set statistics
	logic [CW-1:0] count_q;
	logic [SW-1:0] max_q, min_q;

	// walk state
	logic [CW-1:0]        idx_q, ptr_q;
	logic [AW-1:0]        seg_q, st_q;
	logic [VW-1:0]        vi_q, avg_q, prev_q, vst_q, acc_q;
	logic signed [VW:0]   jump_q, slope_q;
	logic                 ljneg_q;
	logic signed [33:0]   pc_q;
	logic [31:0]          pt_q;
	logic signed [VW+1:0] cutoff_q;
	logic [VW-1:0]        thr_q;

	// output register
	logic          ov_q;
	logic [SW-1:0] fd_q;
	logic          lo_q;

	// ram ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [VW-1:0] ram_wd, ram_rd;

	logic [VW-1:0]        rhq;
	logic signed [16:0]   span;
	logic signed [VW:0]   ctrunc;
	logic [VW-1:0]        cut_val;
	logic [VW:0]          jabs;
	logic [AW-1:0]        st_c;
	logic                 last_item;
	logic                 div_go, div_done;
	logic signed [VW:0]   div_num, div_quo;
	logic [DENW-1:0]      div_den;
	logic [VW-1:0]        acc_next;

	assign rhq  = {rh_q, 8'd0};
	assign span = $signed({1'b0, rh_q}) - $signed({1'b0, rl_q});

	// cutoff product truncated toward zero
	assign ctrunc = pc_q[33] ? (VW+1)'((pc_q + 34'sd255) >>> 8) : (VW+1)'(pc_q >>> 8);

	// substitution above the cutoff
	assign cut_val = ($signed({2'b00, ram_rd}) > cutoff_q) ? rhq : ram_rd;

	assign jabs      = jump_q[VW] ? (VW+1)'(-jump_q) : (VW+1)'(jump_q);
	assign st_c      = seg_q - ((seg_q != '0) ? AW'(1) : AW'(0));
	assign last_item = (idx_q + CW'(1)) == count_q;
	assign acc_next  = VW'($signed({2'b00, acc_q}) + (VW+2)'(slope_q));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q    <= 16'd0;
			rh_q    <= 16'd65535;
			frac_q  <= 16'd6554;
			spike_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spk_pkg::REG_RANGE_LOW:   rl_q    <= cfg_data;
				spk_pkg::REG_RANGE_HIGH:  rh_q    <= cfg_data;
				spk_pkg::REG_FRACTION:    frac_q  <= cfg_data;
				spk_pkg::REG_SPIKE_WIDTH: spike_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sample count and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= '1;
		end else if (cmd.clear) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= '1;
		end else if (cmd.load && count_q < CW'(MAX_SAMPLES)) begin
			count_q <= count_q + CW'(1);
			if (distance > max_q) begin
				max_q <= distance;
			end
			if (distance < min_q) begin
				min_q <= distance;
			end
		end
	end

	// ram port selection
	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q[AW-1:0];
		ram_wd = vi_q;
		ram_re = 1'b0;
		ram_ra = idx_q[AW-1:0];
		if (cmd.load) begin
			ram_we = count_q < CW'(MAX_SAMPLES);
			ram_wa = count_q[AW-1:0];
			ram_wd = {distance, 8'd0};
		end else if (cmd.cut) begin
			ram_we = 1'b1;
			ram_wd = cut_val;
		end else if (cmd.fill_wr) begin
			ram_we = 1'b1;
			ram_wa = ptr_q[AW-1:0];
			ram_wd = avg_q;
		end else if (cmd.ramp_wr) begin
			ram_we = 1'b1;
			ram_wa = ptr_q[AW-1:0];
			ram_wd = acc_q;
		end
		if (cmd.rd_cur) begin
			ram_re = 1'b1;
		end else if (cmd.rst) begin
			ram_re = 1'b1;
			ram_ra = st_c;
		end else if (cmd.out_rd) begin
			ram_re = 1'b1;
			ram_ra = ptr_q[AW-1:0];
		end
	end

	spk_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	// divider operand selection
	always_comb begin
		div_go  = cmd.slope_go | cmd.avg_go;
		div_num = $signed({1'b0, vi_q}) - $signed({1'b0, avg_q});
		div_den = DENW'(idx_q - CW'(seg_q)) + DENW'(1);
		if (cmd.slope_go) begin
			div_num = $signed({1'b0, vi_q}) - $signed({1'b0, vst_q});
			div_den = DENW'(idx_q - CW'(st_q));
		end
	end

	spk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// limits, segment walk and ramp registers
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			pc_q <= span * $signed({1'b0, frac_q});
			pt_q <= (max_q - min_q) * frac_q;
		end
		if (cmd.lim) begin
			cutoff_q <= $signed({2'b00, rhq}) - (VW+2)'(ctrunc);
			thr_q    <= pt_q[31:8];
			idx_q    <= '0;
			seg_q    <= '0;
			avg_q    <= '0;
			prev_q   <= rhq;
			ljneg_q  <= 1'b0;
		end
		if (cmd.cut) begin
			vi_q <= cut_val;
		end
		if (cmd.jmp) begin
			jump_q <= $signed({1'b0, last_item ? rhq : vi_q}) - $signed({1'b0, prev_q});
		end
		if (cmd.fill_init) begin
			ptr_q <= CW'(seg_q);
		end
		if (cmd.fill_wr) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.rst) begin
			st_q <= st_c;
			if (st_c != '0 && last_item) begin
				vi_q <= rhq;
			end
		end
		if (cmd.rst2) begin
			vst_q <= (st_q == '0) ? rhq : ram_rd;
		end
		if (cmd.slope_take) begin
			slope_q <= div_quo;
			acc_q   <= vst_q;
			ptr_q   <= CW'(st_q);
		end
		if (cmd.ramp_wr) begin
			if (ptr_q == idx_q) begin
				vi_q <= acc_q;
			end else begin
				acc_q <= acc_next;
				ptr_q <= ptr_q + CW'(1);
			end
		end
		if (cmd.close) begin
			avg_q   <= '0;
			seg_q   <= idx_q[AW-1:0];
			ljneg_q <= jump_q[VW];
		end
		if (cmd.avg_take) begin
			avg_q  <= VW'($signed({1'b0, avg_q}) + div_quo);
			prev_q <= vi_q;
			idx_q  <= idx_q + CW'(1);
			ptr_q  <= '0;
		end
		if (cmd.out_next) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.out_load) begin
			fd_q <= ram_rd[VW-1:8];
			lo_q <= (ptr_q + CW'(1)) == count_q;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// status to the controller
	always_comb begin
		stat.big       = jabs > {1'b0, thr_q};
		stat.is_ramp   = ljneg_q && !jump_q[VW] && (jump_q != '0)
		                 && (8'(idx_q - CW'(seg_q)) <= spike_q);
		stat.seg_eq_i  = CW'(seg_q) == idx_q;
		stat.fill_done = (ptr_q + CW'(1)) == idx_q;
		stat.div_done  = div_done;
		stat.ramp_done = ptr_q == idx_q;
		stat.last_item = last_item;
		stat.out_fire  = ov_q & out_ready;
		stat.out_last  = lo_q;
	end

	assign out_valid         = ov_q;
	assign filtered_distance = fd_q;
	assign last_out          = lo_q;

endmodule

// ----- hdl/spk_ctrl.sv -----
// controller state machine sequencing load, filter walk and output
module spk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_sample,
	output logic               in_ready,
	output spk_pkg::spk_cmd_t  cmd,
	input  spk_pkg::spk_stat_t stat
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_PREP  = 5'd1;
	localparam logic [4:0] S_LIM   = 5'd2;
	localparam logic [4:0] S_RD    = 5'd3;
	localparam logic [4:0] S_CUT   = 5'd4;
	localparam logic [4:0] S_JMP   = 5'd5;
	localparam logic [4:0] S_DEC   = 5'd6;
	localparam logic [4:0] S_FILL  = 5'd7;
	localparam logic [4:0] S_RST   = 5'd8;
	localparam logic [4:0] S_RST2  = 5'd9;
	localparam logic [4:0] S_SGO   = 5'd10;
	localparam logic [4:0] S_SDIV  = 5'd11;
	localparam logic [4:0] S_RWR   = 5'd12;
	localparam logic [4:0] S_CLOSE = 5'd13;
	localparam logic [4:0] S_AVG   = 5'd14;
	localparam logic [4:0] S_ADIV  = 5'd15;
	localparam logic [4:0] S_ORD   = 5'd16;
	localparam logic [4:0] S_OLD   = 5'd17;
	localparam logic [4:0] S_OWT   = 5'd18;
	localparam logic [4:0] S_CLR   = 5'd19;

	logic [4:0] state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_sample) begin
						state_d = S_PREP;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_LIM;
			end
			S_LIM: begin
				cmd.lim = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_CUT;
			end
			S_CUT: begin
				cmd.cut = 1'b1;
				state_d = S_JMP;
			end
			S_JMP: begin
				cmd.jmp = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (!stat.big) begin
					state_d = S_AVG;
				end else if (stat.is_ramp) begin
					state_d = S_RST;
				end else if (stat.seg_eq_i) begin
					state_d = S_CLOSE;
				end else begin
					cmd.fill_init = 1'b1;
					state_d       = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (stat.fill_done) begin
					state_d = S_CLOSE;
				end
			end
			S_RST: begin
				cmd.rst = 1'b1;
				state_d = S_RST2;
			end
			S_RST2: begin
				cmd.rst2 = 1'b1;
				state_d  = S_SGO;
			end
			S_SGO: begin
				cmd.slope_go = 1'b1;
				state_d      = S_SDIV;
			end
			S_SDIV: begin
				if (stat.div_done) begin
					cmd.slope_take = 1'b1;
					state_d        = S_RWR;
				end
			end
			S_RWR: begin
				cmd.ramp_wr = 1'b1;
				if (stat.ramp_done) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = S_AVG;
			end
			S_AVG: begin
				cmd.avg_go = 1'b1;
				state_d    = S_ADIV;
			end
			S_ADIV: begin
				if (stat.div_done) begin
					cmd.avg_take = 1'b1;
					state_d      = stat.last_item ? S_ORD : S_RD;
				end
			end
			S_ORD: begin
				cmd.out_rd = 1'b1;
				state_d    = S_OLD;
			end
			S_OLD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OWT;
			end
			S_OWT: begin
				if (stat.out_fire) begin
					if (stat.out_last) begin
						state_d = S_CLR;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = S_ORD;
					end
				end
			end
			S_CLR: begin
				cmd.clear = 1'b1;
				state_d   = S_LOAD;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

// ----- test/distance_spike_filter_tb.sv -----
// testbench for the distance spike filter: directed and random sets checked against a built-in predictor
module distance_spike_filter_tb;

	localparam int SW          = spk_pkg::SW;
	localparam int IDXW        = spk_pkg::IDXW;
	localparam int STORE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_GOAL   = 410;

	typedef struct {
		logic [SW-1:0] dval;
		logic          last;
	} filtered_beat_t;

	// filter predictor and store of expected filtered beats
	class filter_scoreboard;
		logic [SW-1:0]  range_low_q   = 16'd0;
		logic [SW-1:0]  upper_q       = 16'hffff;
		logic [SW-1:0]  fraction_q    = 16'd6554;
		logic [7:0]     spike_width_q = 8'd3;
		logic [SW-1:0]  store [STORE_DEPTH];
		int             count_q  = 0;
		logic [SW-1:0]  max_q    = 16'd0;
		logic [SW-1:0]  min_q    = 16'hffff;
		filtered_beat_t pending[$];
		int             mismatches = 0;
		int             beats_seen = 0;
		int             sets_seen  = 0;

		function void write_reg(logic [IDXW-1:0] idx, logic [SW-1:0] data);
			case (idx)
				spk_pkg::REG_RANGE_LOW:   range_low_q   = data;
				spk_pkg::REG_RANGE_HIGH:  upper_q       = data;
				spk_pkg::REG_FRACTION:    fraction_q    = data;
				spk_pkg::REG_SPIKE_WIDTH: spike_width_q = data[7:0];
				default: ;
			endcase
		endfunction

		// take one accepted sample; on the last one filter the whole set
		function void note_input(logic [SW-1:0] d, logic last);
			longint v [STORE_DEPTH];
			longint rh, cutoff, thr, avg, lj, prev, jump, slope, q, mag;
			int n, seg, st;
			logic dip;
			filtered_beat_t b;
			if (count_q < STORE_DEPTH) begin
				store[count_q] = d;
				count_q++;
				if (d > max_q) max_q = d;
				if (d < min_q) min_q = d;
			end
			if (!last) return;
			n = count_q;
			rh = longint'(upper_q) * 256;
			cutoff = rh - (longint'(upper_q) - longint'(range_low_q))
				* longint'(fraction_q) / 256;
			thr = (longint'(max_q) - longint'(min_q)) * longint'(fraction_q) / 256;
			prev = rh;
			avg = 0;
			seg = 0;
			lj = 0;
			for (int i = 0; i < n; i++) v[i] = longint'(store[i]) * 256;
			for (int i = 0; i < n; i++) begin
				if (v[i] > cutoff) v[i] = rh;
				jump = (i != n - 1) ? v[i] - prev : rh - prev;
				mag = jump < 0 ? -jump : jump;
				if (mag > thr) begin
					dip = (lj < 0) && (jump > 0);
					for (int j = seg; j < i; j++) v[j] = avg;
					// short dip becomes a ramp, pinned to the upper limit at the edges
					if (dip && (i - seg) <= int'(spike_width_q)) begin
						st = seg - ((seg != 0) ? 1 : 0);
						slope = 0;
						if (st == 0) v[0] = rh;
						else if (i == n - 1) v[i] = rh;
						if (i > st) slope = (v[i] - v[st]) / longint'(i - st);
						for (int j = st; j <= i; j++) v[j] = v[st] + slope * longint'(j - st);
					end
					avg = 0;
					seg = i;
					lj = jump;
				end
				avg = avg + (v[i] - avg) / longint'(i - seg + 1);
				prev = v[i];
			end
			for (int i = 0; i < n; i++) begin
				q = v[i] < 0 ? 0 : v[i] / 256;
				if (q > 65535) q = 65535;
				b.dval = q[SW-1:0];
				b.last = (i == n - 1);
				pending.push_back(b);
			end
			count_q = 0;
			max_q = 16'd0;
			min_q = 16'hffff;
			sets_seen++;
		endfunction

		function void check_result(logic [SW-1:0] d, logic last);
			filtered_beat_t e;
			beats_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: dist %0d last %0b", d, last);
				return;
			end
			e = pending.pop_front();
			if (d !== e.dval || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at beat %0d: expected dist %0d last %0b, got dist %0d last %0b",
						beats_seen, e.dval, e.last, d, last);
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [SW-1:0]   distance = '0;
	logic            last_sample = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [SW-1:0]   filtered_distance;
	logic            last_out;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [IDXW-1:0] cfg_index = '0;
	logic [SW-1:0]   cfg_data = '0;

	filter_scoreboard sb = new();
	int  cycles = 0;
	int  items_sent = 0;
	int  cfg_writes = 0;
	bit  quiet = 1'b0;
	int  stall_left = 0;

	distance_spike_filter dut (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// output side with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// check each output beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(filtered_distance, last_out);
	end

	task automatic send_sample(logic [SW-1:0] d, logic last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		last_sample <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_input(d, last);
		items_sent++;
	endtask

	// drop valid and wait until every expected beat has gone, plus the tail latency
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, logic [SW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [SW-1:0] lo, logic [SW-1:0] hi, logic [SW-1:0] fr,
			logic [7:0] sw);
		drain();
		write_reg(spk_pkg::REG_RANGE_LOW, lo);
		write_reg(spk_pkg::REG_RANGE_HIGH, hi);
		write_reg(spk_pkg::REG_FRACTION, fr);
		write_reg(spk_pkg::REG_SPIKE_WIDTH, {8'd0, sw});
	endtask

	// one set: flat base with short dips, or pure noise; last beat flagged
	task automatic send_set(int len, bit noisy);
		logic [SW-1:0] base, depth, d;
		int dip_left;
		base = 16'($urandom_range(0, 65535));
		depth = 16'($urandom_range(0, 65535));
		dip_left = 0;
		for (int i = 0; i < len; i++) begin
			if (noisy) d = 16'($urandom_range(0, 65535));
			else begin
				if (dip_left == 0 && $urandom_range(0, 4) == 0) dip_left = $urandom_range(1, 5);
				d = 16'(base + $urandom_range(0, 200));
				if (dip_left > 0) begin
					d = (base > depth) ? 16'(base - depth) : 16'($urandom_range(0, 100));
					dip_left--;
				end
			end
			send_sample(d, i == len - 1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		configure(16'd0, 16'd50000, 16'd6554, 8'd3);

		// directed sets: single sample, extremes, dips in the middle and at both edges
		send_sample(16'd1234, 1'b1);
		send_sample(16'd0, 1'b0);
		send_sample(16'hffff, 1'b1);
		send_sample(16'd1000, 1'b0); send_sample(16'd1000, 1'b0); send_sample(16'd200, 1'b0);
		send_sample(16'd200, 1'b0); send_sample(16'd1000, 1'b0); send_sample(16'd1000, 1'b1);
		send_sample(16'd100, 1'b0); send_sample(16'd3000, 1'b0); send_sample(16'd3000, 1'b0);
		send_sample(16'd3000, 1'b1);
		send_sample(16'd3000, 1'b0); send_sample(16'd3000, 1'b0); send_sample(16'd10, 1'b0);
		send_sample(16'd10, 1'b1);
		configure(16'd60000, 16'd1000, 16'd0, 8'd0);
		send_sample(16'd5000, 1'b0); send_sample(16'd0, 1'b0); send_sample(16'd5000, 1'b1);
		configure(16'hffff, 16'hffff, 16'hffff, 8'd255);
		send_sample(16'd40000, 1'b0); send_sample(16'd100, 1'b0); send_sample(16'd40000, 1'b1);

		// random sets, settings changed now and then, extremes included
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: configure(16'd0, 16'hffff, 16'd0, 8'd0);
					1: configure(16'hffff, 16'd0, 16'hffff, 8'd255);
					default: configure(16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 8'($urandom_range(0, 8)));
				endcase
			end
			if ($urandom_range(0, 19) == 0) drain();
			if (items_sent > 340) quiet = 1'b1;
			if ($urandom_range(0, 40) == 0)
				send_set(int'($urandom_range(64, 68)), 1'($urandom_range(0, 1)));
			else send_set(int'($urandom_range(1, 12)), $urandom_range(0, 4) == 0);
		end
		drain();

		$display("covered %0d samples in %0d sets, %0d output beats, %0d register writes",
			items_sent, sb.sets_seen, sb.beats_seen, cfg_writes);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
